// ===== rtl/esd_pkg.sv =====
// Package for the event stream deframer: constants, state/tag types, helpers.
`timescale 1ns / 1ps

package esd_pkg;

  localparam int GH_LEN    = 20;  // global header bytes
  localparam int FH_LEN    = 16;  // frame header bytes
  localparam int TR_LEN    = 30;  // trailer bytes
  localparam int FIRST_GAP = 8;
  localparam int NEXT_GAP  = 4;
  localparam int EV_ADJ    = 4;
  localparam int SIZE_LEN  = 4;   // bytes of a little-endian size word

  typedef logic signed [32:0] pos_t;

  typedef struct packed {
    logic [31:0] byte_position;
    logic [31:0] event_length;
    logic [31:0] frame_length;
    logic [31:0] next_frame_header_pos;
    logic [31:0] frame_header_end_pos;
    logic [31:0] payload_start_pos;
    logic [31:0] payload_end_pos;
    logic [31:0] size_assembly;
    logic [4:0]  frame_header_index;
  } esd_state_t;

  typedef struct packed {
    logic to_header;
    logic to_payload;
    logic to_trailer;
    logic trailer_done;
  } esd_tags_t;

  // Sign-extend a 32-bit position to the 33-bit compare width.
  function automatic pos_t sx(input logic [31:0] v);
    return pos_t'({v[31], v});
  endfunction

  // Replace one byte lane of a little-endian word.
  function automatic logic [31:0] put_byte(input logic [31:0] word,
                                           input logic [1:0]  idx,
                                           input logic [7:0]  b);
    logic [31:0] w;
    w = word;
    w[idx*8 +: 8] = b;
    return w;
  endfunction

endpackage

// ===== rtl/esd_tagger.sv =====
// Combinational core: tags one byte and computes the next deframer state.
`timescale 1ns / 1ps

module esd_tagger import esd_pkg::*; (
  input  esd_state_t state_i,
  input  logic [7:0] byte_i,
  input  logic       first_i,
  output esd_state_t state_o,
  output esd_tags_t  tags_o
);

  esd_state_t st;
  esd_tags_t  tg;
  pos_t       pos;
  pos_t       nbe;
  pos_t       tstart;

  always_comb begin
    st = state_i;
    if (first_i) begin
      st = '0;
    end
    tg  = '0;
    pos = pos_t'({1'b0, st.byte_position});

    // global header; size words gathered from bytes 0..7
    if (pos < pos_t'(GH_LEN)) begin
      tg.to_header = 1'b1;
      if (pos < pos_t'(SIZE_LEN)) begin
        st.size_assembly = put_byte(st.size_assembly, pos[1:0], byte_i);
      end else if (pos < pos_t'(2 * SIZE_LEN)) begin
        st.frame_length = put_byte(st.frame_length, pos[1:0], byte_i);
      end
    end

    if (pos == pos_t'(GH_LEN)) begin
      st.next_frame_header_pos = st.next_frame_header_pos + st.frame_length
                                 + 32'(FIRST_GAP);
      st.frame_header_end_pos  = st.next_frame_header_pos + 32'(FH_LEN);
      st.event_length          = st.size_assembly - 32'(EV_ADJ);
      st.payload_start_pos     = st.payload_start_pos + 32'(GH_LEN);
      st.payload_end_pos       = st.next_frame_header_pos;
    end

    nbe    = sx(st.event_length);
    tstart = nbe - pos_t'(TR_LEN);

    // inside a frame header
    if (pos > pos_t'(GH_LEN) && pos >= sx(st.next_frame_header_pos) &&
        pos < sx(st.frame_header_end_pos) && pos < nbe) begin
      if (pos == sx(st.next_frame_header_pos)) begin
        st.frame_header_index = '0;
      end
      if (st.frame_header_index < 5'(SIZE_LEN)) begin
        st.size_assembly = put_byte(st.size_assembly, st.frame_header_index[1:0], byte_i);
      end
      tg.to_header = 1'b1;
      if (st.frame_header_index < 5'(FH_LEN)) begin
        st.frame_header_index = st.frame_header_index + 5'd1;
      end
    end

    // end of a frame header: schedule the next frame
    if (pos > pos_t'(GH_LEN) && pos == sx(st.frame_header_end_pos) &&
        pos < nbe && pos < tstart) begin
      st.frame_length          = st.size_assembly;
      st.next_frame_header_pos = st.next_frame_header_pos + st.frame_length
                                 + 32'(NEXT_GAP);
      st.frame_header_end_pos  = st.next_frame_header_pos + 32'(FH_LEN);
      st.payload_start_pos     = st.payload_end_pos + 32'(FH_LEN);
      st.payload_end_pos       = st.next_frame_header_pos;
    end

    // payload, clipped at the trailer start
    if (pos > pos_t'(0) && pos >= sx(st.payload_start_pos) && pos < tstart &&
        pos < sx(st.payload_end_pos)) begin
      if (sx(st.payload_end_pos) > tstart) begin
        st.payload_end_pos = tstart[31:0];
      end
      tg.to_payload = 1'b1;
    end

    if (pos > pos_t'(GH_LEN) && pos >= tstart && pos < nbe) begin
      tg.to_trailer = 1'b1;
    end
    if (pos > pos_t'(GH_LEN) && pos == nbe) begin
      tg.trailer_done = 1'b1;
    end

    st.byte_position = st.byte_position + 32'd1;
  end

  assign state_o = st;
  assign tags_o  = tg;

endmodule

// ===== rtl/event_stream_deframer_top.sv =====
// Top level of the event stream deframer: input stage, state and result register.
`timescale 1ns / 1ps

// Tags each event byte as global/frame header, payload and/or trailer and
// flags the byte at the adjusted event count. One byte per clock sustained
// while out_stall is low. A transfer loads the input register, and the byte
// moves on to the result register once that register is empty or its byte
// is taken. The byte is tagged and the position state updated in the cycle
// it moves from the input register to the result register, so consecutive
// bytes never wait on each other. Assert in_first_of_event on byte zero of
// each event to restart the position count.
module event_stream_deframer_top import esd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_event_byte,
  input  logic       in_first_of_event,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_to_header,
  output logic       out_to_payload,
  output logic       out_to_trailer,
  output logic       out_trailer_done
);

  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_first_r;
  esd_state_t state_r;
  esd_state_t state_nxt;
  esd_tags_t  tags_nxt;
  esd_tags_t  out_tags_r;
  logic [7:0] out_byte_r;
  logic       out_v_r;
  logic       advance;

  esd_tagger u_tagger (
    .state_i (state_r),
    .byte_i  (s1_byte_r),
    .first_i (s1_first_r),
    .state_o (state_nxt),
    .tags_o  (tags_nxt)
  );

  assign advance  = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '0;
    end else begin
      if (!in_stall) begin
        s1_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        state_r <= state_nxt;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r  <= in_event_byte;
      s1_first_r <= in_first_of_event;
    end
    if (advance) begin
      out_byte_r <= s1_byte_r;
      out_tags_r <= tags_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_byte         = out_byte_r;
  assign out_to_header    = out_tags_r.to_header;
  assign out_to_payload   = out_tags_r.to_payload;
  assign out_to_trailer   = out_tags_r.to_trailer;
  assign out_trailer_done = out_tags_r.trailer_done;

endmodule
